/* rtl/tanp_pkg.sv */
// ----------------------------------------------------------------------------
// tanp_pkg
// Shared types, constants and the arctangent table for the tilt angle block.
// ----------------------------------------------------------------------------
package tanp_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int CORDIC_STEPS    = 16;
	localparam int TAB_FRAC        = 24;
	localparam int SUM_W           = 32;
	localparam int CFG_W           = 10;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_RADIUS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_DEGREES = 2'd3;

	localparam logic [9:0] CENTER_X_RST      = 10'd240;
	localparam logic [9:0] CENTER_Y_RST      = 10'd272;
	localparam logic [8:0] NEEDLE_RADIUS_RST = 9'd128;
	localparam logic [6:0] ALARM_DEGREES_RST = 7'd60;

	localparam logic signed [31:0] NINETY_Q     = 32'sd1509949440;
	localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic signed [11:0] needle_x;
		logic signed [11:0] needle_y;
		logic               tilt_alarm;
	} result_t;

	// atan(2^-i) in degrees, 24 fraction bits, rounded
	function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
		case (i)
			5'd0:    atan_q24 = 32'sd754974720;
			5'd1:    atan_q24 = 32'sd445687602;
			5'd2:    atan_q24 = 32'sd235489088;
			5'd3:    atan_q24 = 32'sd119537938;
			5'd4:    atan_q24 = 32'sd60000934;
			5'd5:    atan_q24 = 32'sd30029717;
			5'd6:    atan_q24 = 32'sd15018523;
			5'd7:    atan_q24 = 32'sd7509720;
			5'd8:    atan_q24 = 32'sd3754917;
			5'd9:    atan_q24 = 32'sd1877466;
			5'd10:   atan_q24 = 32'sd938734;
			5'd11:   atan_q24 = 32'sd469367;
			5'd12:   atan_q24 = 32'sd234684;
			5'd13:   atan_q24 = 32'sd117342;
			5'd14:   atan_q24 = 32'sd58671;
			5'd15:   atan_q24 = 32'sd29335;
			5'd16:   atan_q24 = 32'sd14668;
			5'd17:   atan_q24 = 32'sd7334;
			5'd18:   atan_q24 = 32'sd3667;
			5'd19:   atan_q24 = 32'sd1833;
			5'd20:   atan_q24 = 32'sd917;
			5'd21:   atan_q24 = 32'sd458;
			5'd22:   atan_q24 = 32'sd229;
			5'd23:   atan_q24 = 32'sd115;
			default: atan_q24 = 32'sd0;
		endcase
	endfunction

endpackage

/* rtl/tanp_sqrt.sv */
// ----------------------------------------------------------------------------
// tanp_sqrt
// Pipelined integer square root of (value * 2^16), one root bit per stage.
// ----------------------------------------------------------------------------
module tanp_sqrt #(
	parameter int IN_W   = tanp_pkg::SUM_W,
	parameter int SIDE_W = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [IN_W-1:0]            value,
	input  logic [SIDE_W-1:0]          side_in,
	output logic                       out_vld,
	output logic [(IN_W+16)/2-1:0]     root,
	output logic [SIDE_W-1:0]          side_out
);

	localparam int RAD_W  = IN_W + 16;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 3;

	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SIDE_W-1:0] side_s [ROOT_W];
	logic              vld_s  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [RAD_W-1:0]  rad_i;
		logic [REM_W-1:0]  rem_i;
		logic [ROOT_W-1:0] root_i;
		logic [SIDE_W-1:0] side_i;
		logic              vld_i;
		logic [REM_W-1:0]  cur;
		logic [REM_W-1:0]  trial;

		if (k == 0) begin : g_first
			assign rad_i  = {value, 16'd0};
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = side_in;
			assign vld_i  = in_vld;
		end else begin : g_next
			assign rad_i  = rad_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign cur   = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
		assign trial = REM_W'({root_i, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k]  <= rad_i << 2;
			side_s[k] <= side_i;
			if (cur >= trial) begin
				rem_s[k]  <= cur - trial;
				root_s[k] <= {root_i[ROOT_W-2:0], 1'b1};
			end else begin
				rem_s[k]  <= cur;
				root_s[k] <= {root_i[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign root     = root_s[ROOT_W-1];
	assign side_out = side_s[ROOT_W-1];

endmodule

/* rtl/tanp_vec.sv */
// ----------------------------------------------------------------------------
// tanp_vec
// Pipelined vectoring CORDIC: atan(256 * num / den) in degrees, clamped and rounded.
// ----------------------------------------------------------------------------
module tanp_vec #(
	parameter int ANGLE_FRAC_BITS = tanp_pkg::ANGLE_FRAC_BITS,
	parameter int CORDIC_STEPS    = tanp_pkg::CORDIC_STEPS,
	parameter int D_W             = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [D_W-1:0]                    den,
	input  logic signed [15:0]                num,
	output logic                              out_vld,
	output logic signed [ANGLE_FRAC_BITS+7:0] angle
);

	localparam int ANG_W = ANGLE_FRAC_BITS + 8;
	localparam int XY_W  = D_W + 3;
	localparam int SH    = tanp_pkg::TAB_FRAC - ANGLE_FRAC_BITS;

	logic signed [XY_W-1:0] x_s  [CORDIC_STEPS];
	logic signed [XY_W-1:0] y_s  [CORDIC_STEPS];
	logic signed [31:0]     z_s  [CORDIC_STEPS];
	logic                   sp_s [CORDIC_STEPS];
	logic signed [31:0]     spz_s[CORDIC_STEPS];
	logic                   vld_s[CORDIC_STEPS];

	// zero denominator or zero numerator bypass the iterations
	logic               sp_in;
	logic signed [31:0] spz_in;

	always_comb begin
		sp_in  = (den == '0) || (num == '0);
		spz_in = 32'sd0;
		if (den == '0) begin
			if (num > 0) begin
				spz_in = tanp_pkg::NINETY_Q;
			end else if (num < 0) begin
				spz_in = -tanp_pkg::NINETY_Q;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XY_W-1:0] x_i;
		logic signed [XY_W-1:0] y_i;
		logic signed [31:0]     z_i;
		logic                   sp_i;
		logic signed [31:0]     spz_i;
		logic                   vld_i;
		logic signed [XY_W-1:0] xs;
		logic signed [XY_W-1:0] ys;

		if (i == 0) begin : g_first
			assign x_i   = XY_W'($signed({1'b0, den}));
			assign y_i   = XY_W'($signed({num, 8'd0}));
			assign z_i   = 32'sd0;
			assign sp_i  = sp_in;
			assign spz_i = spz_in;
			assign vld_i = in_vld;
		end else begin : g_next
			assign x_i   = x_s[i-1];
			assign y_i   = y_s[i-1];
			assign z_i   = z_s[i-1];
			assign sp_i  = sp_s[i-1];
			assign spz_i = spz_s[i-1];
			assign vld_i = vld_s[i-1];
		end

		assign xs = x_i >>> i;
		assign ys = y_i >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			sp_s[i]  <= sp_i;
			spz_s[i] <= spz_i;
			if (y_i >= 0) begin
				x_s[i] <= x_i + ys;
				y_s[i] <= y_i - xs;
				z_s[i] <= z_i + tanp_pkg::atan_q24(5'(i));
			end else begin
				x_s[i] <= x_i - ys;
				y_s[i] <= y_i + xs;
				z_s[i] <= z_i - tanp_pkg::atan_q24(5'(i));
			end
		end
	end

	logic signed [31:0] zc;
	logic signed [31:0] zr;

	always_comb begin
		zc = z_s[CORDIC_STEPS-1];
		if (sp_s[CORDIC_STEPS-1]) begin
			zc = spz_s[CORDIC_STEPS-1];
		end else if (zc > tanp_pkg::NINETY_Q) begin
			zc = tanp_pkg::NINETY_Q;
		end else if (zc < -tanp_pkg::NINETY_Q) begin
			zc = -tanp_pkg::NINETY_Q;
		end
		zr = (zc + (32'sd1 <<< (SH - 1))) >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		angle <= zr[ANG_W-1:0];
	end

endmodule

/* rtl/tilt_angle_needle_position.sv */
// ----------------------------------------------------------------------------
// tilt_angle_needle_position
// Pitch, roll, dial needle end point and tilt alarm from one accel sample.
// ----------------------------------------------------------------------------
// A new item may be started every cycle; busy never rises. Each item comes
// out on done after a squaring stage, a summing stage, 24 square root stages,
// the arctangent CORDIC stages plus a rounding stage, one stage for roll and
// alarm, the sine/cosine CORDIC stages, and three stages for rounding, the
// radius multiply and the end point. The receiver cannot stall; results
// appear for one cycle only. Configuration writes are always ready and
// should be made while no item is in flight.
module tilt_angle_needle_position #(
	parameter int ANGLE_FRAC_BITS = tanp_pkg::ANGLE_FRAC_BITS,
	parameter int CORDIC_STEPS    = tanp_pkg::CORDIC_STEPS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  tanp_pkg::sample_t              sample,
	output logic                           done,
	output tanp_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tanp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tanp_pkg::CFG_W-1:0]     cfg_data
);

	localparam int ANG_W  = ANGLE_FRAC_BITS + 8;
	localparam int SH     = tanp_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
	localparam int SUM_W  = tanp_pkg::SUM_W;
	localparam int ROOT_W = (SUM_W + 16) / 2;
	localparam int LAT    = 2 * CORDIC_STEPS + ROOT_W + 7;

	// ---------------- configuration ----------------
	logic [9:0] center_x_q;
	logic [9:0] center_y_q;
	logic [8:0] radius_q;
	logic [6:0] alarm_deg_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= tanp_pkg::CENTER_X_RST;
			center_y_q  <= tanp_pkg::CENTER_Y_RST;
			radius_q    <= tanp_pkg::NEEDLE_RADIUS_RST;
			alarm_deg_q <= tanp_pkg::ALARM_DEGREES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tanp_pkg::CFG_CENTER_X:      center_x_q  <= cfg_data[9:0];
				tanp_pkg::CFG_CENTER_Y:      center_y_q  <= cfg_data[9:0];
				tanp_pkg::CFG_NEEDLE_RADIUS: radius_q    <= cfg_data[8:0];
				tanp_pkg::CFG_ALARM_DEGREES: alarm_deg_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// ---------------- squares and sums ----------------
	logic               accept;
	logic               v_s1;
	logic [30:0]        sqx_s1, sqy_s1, sqz_s1;
	logic signed [15:0] ax_s1, ay_s1;
	logic               v_s2;
	logic [SUM_W-1:0]   sump_s2, sumr_s2;
	logic signed [15:0] ax_s2, ay_s2;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1  <= 31'(sample.accel_x * sample.accel_x);
		sqy_s1  <= 31'(sample.accel_y * sample.accel_y);
		sqz_s1  <= 31'(sample.accel_z * sample.accel_z);
		ax_s1   <= sample.accel_x;
		ay_s1   <= sample.accel_y;
		sump_s2 <= SUM_W'(sqy_s1) + SUM_W'(sqz_s1);
		sumr_s2 <= SUM_W'(sqx_s1) + SUM_W'(sqz_s1);
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
	end

	// ---------------- magnitudes ----------------
	logic              pq_vld, rq_vld;
	logic [ROOT_W-1:0] pden, rden;
	logic [15:0]       pnum, rnum;

	tanp_sqrt #(.IN_W(SUM_W), .SIDE_W(16)) u_sqrt_pitch (
		.clk(clk), .arst_n(arst_n), .in_vld(v_s2), .value(sump_s2),
		.side_in(ax_s2), .out_vld(pq_vld), .root(pden), .side_out(pnum)
	);

	tanp_sqrt #(.IN_W(SUM_W), .SIDE_W(16)) u_sqrt_roll (
		.clk(clk), .arst_n(arst_n), .in_vld(v_s2), .value(sumr_s2),
		.side_in(ay_s2), .out_vld(rq_vld), .root(rden), .side_out(rnum)
	);

	// ---------------- arctangents ----------------
	logic                    pa_vld, ra_vld;
	logic signed [ANG_W-1:0] pitch_a, roll_a;

	tanp_vec #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .D_W(ROOT_W)
	) u_vec_pitch (
		.clk(clk), .arst_n(arst_n), .in_vld(pq_vld), .den(pden),
		.num($signed(pnum)), .out_vld(pa_vld), .angle(pitch_a)
	);

	tanp_vec #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .D_W(ROOT_W)
	) u_vec_roll (
		.clk(clk), .arst_n(arst_n), .in_vld(rq_vld), .den(rden),
		.num($signed(rnum)), .out_vld(ra_vld), .angle(roll_a)
	);

	// ---------------- roll, alarm ----------------
	logic signed [ANG_W-1:0] roll_neg, roll_mag;
	logic [ANG_W-1:0]        thr;
	logic                    v_s3;
	logic signed [ANG_W-1:0] pitch_s3, roll_s3;
	logic                    alarm_s3;
	logic signed [31:0]      z_s3;

	assign roll_neg = -roll_a;
	assign roll_mag = (roll_neg < 0) ? -roll_neg : roll_neg;
	assign thr      = ANG_W'({alarm_deg_q, {ANGLE_FRAC_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= pa_vld;
		end
	end

	always_ff @(posedge clk) begin
		pitch_s3 <= pitch_a;
		roll_s3  <= roll_neg;
		alarm_s3 <= $unsigned(roll_mag) >= thr;
		z_s3     <= 32'(roll_neg) <<< SH;
	end

	// ---------------- sine / cosine ----------------
	logic signed [31:0]      rx_s   [CORDIC_STEPS];
	logic signed [31:0]      ry_s   [CORDIC_STEPS];
	logic signed [31:0]      rz_s   [CORDIC_STEPS];
	logic signed [ANG_W-1:0] rp_s   [CORDIC_STEPS];
	logic signed [ANG_W-1:0] rr_s   [CORDIC_STEPS];
	logic                    ral_s  [CORDIC_STEPS];
	logic                    rv_s   [CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		logic signed [31:0]      x_i, y_i, z_i, xs, ys;
		logic signed [ANG_W-1:0] p_i, r_i;
		logic                    al_i, v_i;

		if (k == 0) begin : g_first
			assign x_i  = tanp_pkg::INV_GAIN_Q30;
			assign y_i  = 32'sd0;
			assign z_i  = z_s3;
			assign p_i  = pitch_s3;
			assign r_i  = roll_s3;
			assign al_i = alarm_s3;
			assign v_i  = v_s3;
		end else begin : g_next
			assign x_i  = rx_s[k-1];
			assign y_i  = ry_s[k-1];
			assign z_i  = rz_s[k-1];
			assign p_i  = rp_s[k-1];
			assign r_i  = rr_s[k-1];
			assign al_i = ral_s[k-1];
			assign v_i  = rv_s[k-1];
		end

		assign xs = x_i >>> k;
		assign ys = y_i >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[k] <= 1'b0;
			end else begin
				rv_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			rp_s[k]  <= p_i;
			rr_s[k]  <= r_i;
			ral_s[k] <= al_i;
			if (z_i >= 0) begin
				rx_s[k] <= x_i - ys;
				ry_s[k] <= y_i + xs;
				rz_s[k] <= z_i - tanp_pkg::atan_q24(5'(k));
			end else begin
				rx_s[k] <= x_i + ys;
				ry_s[k] <= y_i - xs;
				rz_s[k] <= z_i + tanp_pkg::atan_q24(5'(k));
			end
		end
	end

	// ---------------- end point ----------------
	localparam int L = CORDIC_STEPS - 1;

	logic signed [31:0]      cos_r, sin_r;
	logic                    v_s4, v_s5, v_s6;
	logic signed [17:0]      cos_s4, sin_s4;
	logic signed [ANG_W-1:0] pitch_s4, roll_s4, pitch_s5, roll_s5;
	logic                    alarm_s4, alarm_s5;
	logic signed [27:0]      psin_s5, pcos_s5;
	logic signed [28:0]      sx, sy;
	logic signed [28:0]      tx, ty;
	logic signed [31:0]      pe, re;
	logic signed [15:0]      psat, rsat;
	tanp_pkg::result_t       res_s6;

	assign cos_r = (rx_s[L] + 32'sd8192) >>> 14;
	assign sin_r = (ry_s[L] + 32'sd8192) >>> 14;

	always_comb begin
		sx = 29'($signed({3'b0, center_x_q, 16'd0})) + 29'(psin_s5);
		sy = 29'($signed({3'b0, center_y_q, 16'd0})) - 29'(pcos_s5);
		// truncate toward zero
		tx = (sx < 0) ? ((sx + 29'sd65535) >>> 16) : (sx >>> 16);
		ty = (sy < 0) ? ((sy + 29'sd65535) >>> 16) : (sy >>> 16);
		pe = 32'(pitch_s5);
		re = 32'(roll_s5);
		psat = (pe > 32'sd32767) ? 16'sh7fff :
			(pe < -32'sd32768) ? 16'sh8000 : pe[15:0];
		rsat = (re > 32'sd32767) ? 16'sh7fff :
			(re < -32'sd32768) ? 16'sh8000 : re[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= rv_s[L];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		cos_s4   <= cos_r[17:0];
		sin_s4   <= sin_r[17:0];
		pitch_s4 <= rp_s[L];
		roll_s4  <= rr_s[L];
		alarm_s4 <= ral_s[L];
		psin_s5  <= 28'($signed({1'b0, radius_q}) * sin_s4);
		pcos_s5  <= 28'($signed({1'b0, radius_q}) * cos_s4);
		pitch_s5 <= pitch_s4;
		roll_s5  <= roll_s4;
		alarm_s5 <= alarm_s4;
		res_s6.pitch_angle <= psat;
		res_s6.roll_angle  <= rsat;
		res_s6.needle_x    <= tx[11:0];
		res_s6.needle_y    <= ty[11:0];
		res_s6.tilt_alarm  <= alarm_s5;
	end

	assign done   = v_s6;
	assign result = res_s6;

	// ---------------- checks ----------------
	a_sqrt_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		pq_vld == rq_vld)
		else $error("square root units out of step");

	a_vec_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		pa_vld == ra_vld)
		else $error("arctangent units out of step");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching item");

endmodule

/* verif/tilt_angle_needle_position_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_angle_needle_position_chk
// Watches the sample, result and register channels of the tilt block. It
// computes pitch, roll, needle end point and alarm for each accepted item
// and compares them as a whole with the results in order.
// ----------------------------------------------------------------------------
module tilt_angle_needle_position_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  tanp_pkg::sample_t              sample,
	input  logic                           done,
	input  tanp_pkg::result_t              result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [tanp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tanp_pkg::CFG_W-1:0]     cfg_data,
	output int                             fails,
	output int                             pending
);
	import tanp_pkg::*;

	localparam longint ATAN_TAB [24] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115
	};
	localparam longint NINETY = longint'(90) << TAB_FRAC;

	logic [9:0] cx;
	logic [9:0] cy;
	logic [8:0] radius;
	logic [6:0] alarm_deg;
	result_t    tilt_q[$];

	function automatic longint root_floor(longint unsigned v);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v -= res + bit_w;
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return longint'(res);
	endfunction

	// atan(n / |a,b|) in degrees, 24 fraction bits, clamped to +-90
	function automatic longint tilt_deg(longint n, longint a, longint b);
		longint x, y, z, xs, ys;
		x = root_floor(longint'((a * a + b * b) << 16));
		y = n * 256;
		z = 0;
		if (x == 0)
			return n > 0 ? NINETY : (n < 0 ? -NINETY : 0);
		if (n == 0)
			return 0;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += ATAN_TAB[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_TAB[i];
			end
		end
		if (z > NINETY) z = NINETY;
		if (z < -NINETY) z = -NINETY;
		return z;
	endfunction

	function automatic longint round_deg(longint z);
		int s;
		s = TAB_FRAC - ANGLE_FRAC_BITS;
		return (z + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic [15:0] sat16(longint q);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function automatic longint trunc16(longint v);
		return v >= 0 ? (v >>> 16) : -((-v) >>> 16);
	endfunction

	function automatic result_t tilt_predict(sample_t s);
		result_t r;
		longint pitch, roll, x, y, z, xs, ys, sin16, cos16, mag;
		pitch = round_deg(tilt_deg(s.accel_x, s.accel_y, s.accel_z));
		roll = -round_deg(tilt_deg(s.accel_y, s.accel_x, s.accel_z));
		x = INV_GAIN_Q30;
		y = 0;
		z = roll * (longint'(1) << (TAB_FRAC - ANGLE_FRAC_BITS));
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ATAN_TAB[i];
			end else begin
				x += ys; y -= xs; z += ATAN_TAB[i];
			end
		end
		cos16 = (x + (longint'(1) << 13)) >>> 14;
		sin16 = (y + (longint'(1) << 13)) >>> 14;
		x = trunc16(longint'(cx) * 65536 + longint'(radius) * sin16);
		y = trunc16(longint'(cy) * 65536 - longint'(radius) * cos16);
		mag = roll < 0 ? -roll : roll;
		r.pitch_angle = sat16(pitch);
		r.roll_angle  = sat16(roll);
		r.needle_x    = x[11:0];
		r.needle_y    = y[11:0];
		r.tilt_alarm  = mag >= longint'(alarm_deg) * (longint'(1) << ANGLE_FRAC_BITS);
		return r;
	endfunction

	assign pending = tilt_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cx        <= CENTER_X_RST;
			cy        <= CENTER_Y_RST;
			radius    <= NEEDLE_RADIUS_RST;
			alarm_deg <= ALARM_DEGREES_RST;
			fails     <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CENTER_X:      cx        <= cfg_data[9:0];
					CFG_CENTER_Y:      cy        <= cfg_data[9:0];
					CFG_NEEDLE_RADIUS: radius    <= cfg_data[8:0];
					CFG_ALARM_DEGREES: alarm_deg <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (start && !busy)
				tilt_q.push_back(tilt_predict(sample));
			if (done) begin
				if (tilt_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					fails <= fails + 1;
				end else begin
					want = tilt_q.pop_front();
					if (want !== result) begin
						$display("%0t: mismatch expected p=%0d r=%0d x=%0d y=%0d a=%0b",
							$time, want.pitch_angle, want.roll_angle, want.needle_x,
							want.needle_y, want.tilt_alarm);
						$display("%0t:          actual   p=%0d r=%0d x=%0d y=%0d a=%0b",
							$time, result.pitch_angle, result.roll_angle,
							result.needle_x, result.needle_y, result.tilt_alarm);
						fails <= fails + 1;
					end
				end
			end
		end
	end

endmodule

/* verif/tilt_angle_needle_position_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_angle_needle_position_tb
// Drives directed and random accelerometer samples through the tilt block
// under several dial and alarm settings, with random gaps between items.
// ----------------------------------------------------------------------------
module tilt_angle_needle_position_tb;
	import tanp_pkg::*;

	localparam int DRAIN = 2 * CORDIC_STEPS + 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	sample_t              sample = '0;
	logic                 done;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CENTER_X;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   fails;
	int                   pending;

	always #2 clk = ~clk;

	tilt_angle_needle_position i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tilt_angle_needle_position_chk i_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .fails(fails), .pending(pending)
	);

	// call at a rising edge; leaves cfg_valid high
	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_dial(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y,
			logic [CFG_W-1:0] r, logic [CFG_W-1:0] a);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		reg_write(CFG_CENTER_X, x);
		reg_write(CFG_CENTER_Y, y);
		reg_write(CFG_NEEDLE_RADIUS, r);
		reg_write(CFG_ALARM_DEGREES, a);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, bit gaps);
		int gap;
		sample <= '{accel_x: ax, accel_y: ay, accel_z: az};
		start  <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		gap = gaps ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// mostly plausible gravity vectors, some full-range noise
	task automatic random_burst(int n);
		bit gaps;
		logic signed [15:0] v [3];
		for (int k = 0; k < n; k++) begin
			if (k % 50 == 0)
				gaps = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 5))
				0, 1: foreach (v[j]) v[j] = 16'($urandom);
				2: foreach (v[j]) v[j] = 16'($signed(16'($urandom_range(0, 40))) - 20);
				3: begin
					foreach (v[j])
						v[j] = 16'($signed(16'($urandom_range(0, 1024))) - 512);
					v[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
				end
				default: foreach (v[j])
					v[j] = 16'($signed(16'($urandom_range(0, 33000))) - 16500);
			endcase
			if ($urandom_range(0, 15) == 0)
				v[$urandom_range(0, 2)] = 0;
			send_sample(v[0], v[1], v[2], gaps);
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at reset settings
		send_sample(0, 0, 0, 0);
		send_sample(16'sd5, 0, 0, 0);
		send_sample(-16'sd5, 0, 0, 0);
		send_sample(0, 16'sd9, 0, 1);
		send_sample(0, -16'sd9, 0, 0);
		send_sample(0, 0, 16'sd16384, 0);
		send_sample(0, 0, -16'sd32768, 1);
		send_sample(16'sd32767, 16'sd32767, 16'sd32767, 0);
		send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 0);
		send_sample(16'sd32767, -16'sd32768, 0, 0);
		send_sample(-16'sd32768, 16'sd32767, 16'sd1, 1);
		send_sample(0, 16'sd16384, 16'sd16384, 0);
		send_sample(16'sd1, -16'sd1, 0, 0);
		send_sample(16'sd11585, -16'sd11585, 16'sd11585, 0);
		send_sample(0, 16'sd14189, 16'sd8192, 0);
		send_sample(0, -16'sd14189, 16'sd8192, 1);
		send_sample(16'sd8192, 16'sd14189, 0, 0);
		start <= 1'b0;
		@(posedge clk);
		random_burst(300);

		set_dial(0, 0, 0, 0);
		send_sample(0, 0, 0, 0);
		send_sample(0, 16'sd100, 0, 0);
		start <= 1'b0;
		@(posedge clk);
		random_burst(250);

		set_dial(10'd1023, 10'd1023, 10'd511, 10'd90);
		send_sample(0, 16'sd100, 0, 0);
		send_sample(0, -16'sd100, 0, 0);
		start <= 1'b0;
		@(posedge clk);
		random_burst(300);

		// threshold above 90 via masked data: alarm never rises
		set_dial(10'h3FF, 10'h000, 10'h3FF, 10'h3FF);
		random_burst(250);

		set_dial(10'd512, 10'd384, 10'd1, 10'd1);
		random_burst(200);

		for (int p = 0; p < 3; p++) begin
			set_dial(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
				CFG_W'($urandom_range(0, 91)));
			random_burst(150);
		end

		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
rtl/tanp_pkg.sv
rtl/tanp_sqrt.sv
rtl/tanp_vec.sv
rtl/tilt_angle_needle_position.sv
verif/tilt_angle_needle_position_chk.sv
verif/tilt_angle_needle_position_tb.sv
